// File: rtl/cs3_pkg.sv
`timescale 1ns / 1ps

package cs3_pkg;

    // default component width, signed Q8.8
    localparam int COMPONENT_WIDTH_DEF = 16;

    // result format: signed Q1.14
    localparam int COS_W = 16;

    // number of quotient bits developed by the divider
    localparam int QUOT_W = 16;

    // +1.0 in Q1.14
    localparam logic [QUOT_W-1:0] COS_ONE = 16'd16384;

    // fraction bits added ahead of the square root (Q8.8 squared -> Q16.16 -> norm * 2^16)
    localparam int NORM_SHIFT = 16;

    // numerator is dot << 30; QUOT_W of those bits are produced by the divider steps
    localparam int DOT_SHIFT = 30;

endpackage

// File: rtl/cosine_similarity_3d.sv
`timescale 1ns / 1ps

// Cosine similarity of two 3D vectors, one pair per word.
//
// Input channel (s_): tdata carries u_x, u_y, u_z, v_x, v_y, v_z, each a
// signed Q8.8 component of COMPONENT_WIDTH bits, u_x in the lowest bits.
// Result channel (m_): tdata[15:0] is the cosine in signed Q1.14, saturated
// to +-16384; tdata[16] is zero_length, set when either vector is all zeros
// (the cosine is then 0). Upper tdata bits are zero.
//
// Pipeline registers, in order: the products, the sums, one square root
// step per bit of the norm (COMPONENT_WIDTH + 8 steps), the norm
// product, the aligned numerator, 16 divider steps and the output
// register. Throughput is one word per cycle while the output is not
// stalled.
//
// The whole pipeline advances on one enable: it moves when the output
// register is empty or being taken. When the receiver holds m_tready low
// with a word waiting, every stage holds and s_tready drops; nothing is
// lost or repeated. Reset clears all valid bits; there is no other state.

module cosine_similarity_3d #(
    parameter int COMPONENT_WIDTH = cs3_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // u_x, u_y, u_z, v_x, v_y, v_z (lowest first), zero fill to bytes
    input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0]   s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // cosine[15:0], zero_length[16], zero fill [23:17]
    output logic [23:0] m_tdata
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int SW  = 2 * W;                       // sum of squares
    localparam int DW  = 2 * W + 1;                   // signed dot product
    localparam int XW  = 2 * W + cs3_pkg::NORM_SHIFT; // square root radicand
    localparam int RW  = W + 8;                       // norm
    localparam int PW  = 2 * RW;                      // norm product
    localparam int RMW = PW + 1;                      // divider remainder
    localparam int QW  = cs3_pkg::QUOT_W;
    localparam int ALN = cs3_pkg::DOT_SHIFT - QW;     // numerator pre-shift

    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] r;
    } sq_t;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [QW-1:0]  q;
    } dv_t;

    function automatic sq_t sqrt_step(sq_t a, int k);
        sq_t           o;
        logic [XW-1:0] bitk;
        logic [XW-1:0] trial;
        bitk  = XW'(1) << (2 * (RW - 1 - k));
        trial = a.r + bitk;
        if (a.x >= trial) begin
            o.x = a.x - trial;
            o.r = (a.r >> 1) + bitk;
        end else begin
            o.x = a.x;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    function automatic dv_t div_step(dv_t a, logic [PW-1:0] d);
        dv_t            o;
        logic [RMW-1:0] t;
        t = {a.rem[RMW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            o.rem = t - {1'b0, d};
            o.q   = {a.q[QW-2:0], 1'b1};
        end else begin
            o.rem = t;
            o.q   = {a.q[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: nine products
    logic signed [W-1:0]  comp [6];
    logic signed [SW-1:0] uu_reg [3];
    logic signed [SW-1:0] vv_reg [3];
    logic signed [SW-1:0] uv_reg [3];
    logic                 p_vld_reg;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            comp[i] = s_tdata[i*W +: W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                uu_reg[i] <= comp[i] * comp[i];
                vv_reg[i] <= comp[i+3] * comp[i+3];
                uv_reg[i] <= comp[i] * comp[i+3];
            end
        end
    end

    // ---------------- stage 2: sums, load square root chain (index 0)
    logic [SW-1:0]        su;
    logic [SW-1:0]        sv;
    logic signed [DW-1:0] dot;

    assign su  = SW'(uu_reg[0]) + SW'(uu_reg[1]) + SW'(uu_reg[2]);
    assign sv  = SW'(vv_reg[0]) + SW'(vv_reg[1]) + SW'(vv_reg[2]);
    assign dot = DW'(uv_reg[0]) + DW'(uv_reg[1]) + DW'(uv_reg[2]);

    sq_t                  squ_reg [RW+1];
    sq_t                  sqv_reg [RW+1];
    logic signed [DW-1:0] sdot_reg [RW+1];
    logic                 szero_reg [RW+1];
    logic                 s_vld_reg [RW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            squ_reg[0].x <= {su, (cs3_pkg::NORM_SHIFT)'(0)};
            squ_reg[0].r <= '0;
            sqv_reg[0].x <= {sv, (cs3_pkg::NORM_SHIFT)'(0)};
            sqv_reg[0].r <= '0;
            sdot_reg[0]  <= dot;
            szero_reg[0] <= (su == '0) || (sv == '0);
            for (int k = 0; k < RW; k++) begin
                squ_reg[k+1]   <= sqrt_step(squ_reg[k], k);
                sqv_reg[k+1]   <= sqrt_step(sqv_reg[k], k);
                sdot_reg[k+1]  <= sdot_reg[k];
                szero_reg[k+1] <= szero_reg[k];
            end
        end
    end

    // ---------------- norm product
    logic [PW-1:0] d_reg;
    logic [SW-1:0] mag_reg;
    logic          m_neg_reg;
    logic          m_zero_reg;
    logic          m_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg      <= PW'(squ_reg[RW].r[RW-1:0]) * PW'(sqv_reg[RW].r[RW-1:0]);
            mag_reg    <= sdot_reg[RW][DW-1] ? SW'(-sdot_reg[RW]) : SW'(sdot_reg[RW]);
            m_neg_reg  <= sdot_reg[RW][DW-1];
            m_zero_reg <= szero_reg[RW];
        end
    end

    // ---------------- divider: align, then one quotient bit per stage
    logic [RMW-1:0] rem0;
    assign rem0 = RMW'({mag_reg, ALN'(0)});

    dv_t           dv_reg   [QW+1];
    logic [PW-1:0] dd_reg   [QW+1];
    logic          dsat_reg [QW+1];
    logic          dneg_reg [QW+1];
    logic          dzero_reg[QW+1];
    logic          d_vld_reg[QW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            // quotient would need more than QW bits: saturate
            dsat_reg[0]  <= rem0 >= {1'b0, d_reg};
            dv_reg[0].rem <= (rem0 >= {1'b0, d_reg}) ? '0 : rem0;
            dv_reg[0].q   <= '0;
            dd_reg[0]    <= d_reg;
            dneg_reg[0]  <= m_neg_reg;
            dzero_reg[0] <= m_zero_reg;
            for (int j = 0; j < QW; j++) begin
                dv_reg[j+1]    <= div_step(dv_reg[j], dd_reg[j]);
                dd_reg[j+1]    <= dd_reg[j];
                dsat_reg[j+1]  <= dsat_reg[j];
                dneg_reg[j+1]  <= dneg_reg[j];
                dzero_reg[j+1] <= dzero_reg[j];
            end
        end
    end

    // ---------------- output register
    logic [QW-1:0]             qmag;
    logic [cs3_pkg::COS_W-1:0] cos_val;

    always_comb begin
        if (dsat_reg[QW] || (dv_reg[QW].q > cs3_pkg::COS_ONE)) begin
            qmag = cs3_pkg::COS_ONE;
        end else begin
            qmag = dv_reg[QW].q;
        end
        if (dzero_reg[QW]) begin
            cos_val = '0;
        end else if (dneg_reg[QW]) begin
            cos_val = cs3_pkg::COS_W'(-qmag);
        end else begin
            cos_val = cs3_pkg::COS_W'(qmag);
        end
    end

    logic [23:0] out_data_reg;
    logic        out_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {7'd0, dzero_reg[QW], cos_val};
        end
    end

    // ---------------- valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= RW; k++) begin
                s_vld_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= QW; j++) begin
                d_vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            p_vld_reg    <= s_tvalid;
            s_vld_reg[0] <= p_vld_reg;
            for (int k = 0; k < RW; k++) begin
                s_vld_reg[k+1] <= s_vld_reg[k];
            end
            m_vld_reg    <= s_vld_reg[RW];
            d_vld_reg[0] <= m_vld_reg;
            for (int j = 0; j < QW; j++) begin
                d_vld_reg[j+1] <= d_vld_reg[j];
            end
            out_vld_reg  <= d_vld_reg[QW];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- assertions
    a_zero_cos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] == '0))
        else $error("zero_length word with nonzero cosine");

    a_cos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[15] == 1'b0 && m_tdata[15:0] <= cs3_pkg::COS_ONE) ||
                      (m_tdata[15] == 1'b1 && m_tdata[15:0] >= 16'(-cs3_pkg::COS_ONE))))
        else $error("cosine outside +-1.0");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:17] == '0))
        else $error("fill bits set");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> (!s_tready ##1 (m_tvalid && $stable(m_tdata))))
        else $error("stalled word changed or input not held off");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");

endmodule
